/* hdl/ecss_pkg.sv */
// Shared types and constants of the event countdown display.
// Depends on nothing; the divider, the top level and the checker refer to it by scoped names.
package ecss_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_TIME  = 2'd1;
  localparam logic [1:0] CMD_SCAN  = 2'd2;

  localparam logic KIND_TIME = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  localparam logic [4:0] SEG_E     = 5'd14;
  localparam logic [4:0] SEG_MINUS = 5'd16;
  localparam logic [4:0] SEG_C     = 5'd17;

  localparam logic [7:0] PAT_E     = 8'b11010011;
  localparam logic [7:0] PAT_ZERO  = 8'b10111011;
  localparam logic [7:0] PAT_C     = 8'b10010011;
  localparam logic [7:0] PAT_MINUS = 8'b01000000;
  localparam logic [7:0] PAT_DOT   = 8'b10000000;

  localparam logic [31:0] MAX_START_MIN = 32'd99;
  localparam logic [31:0] MAX_END_MIN   = 32'd999;

  // 2^37/60 and 2^11/10 rounded up; exact for 32-bit and 10-bit dividends
  localparam logic [31:0] RECIP_MINUTE  = 32'h8888_8889;
  localparam logic [31:0] RECIP_DECIMAL = 32'd205;
  localparam int unsigned SHIFT_MINUTE  = 37;
  localparam int unsigned SHIFT_DECIMAL = 11;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b00000001,
    ST_IDLE  = 8'b00000010,
    ST_WALK  = 8'b00000100,
    ST_CMP   = 8'b00001000,
    ST_DIV60 = 8'b00010000,
    ST_DIGA  = 8'b00100000,
    ST_DIGB  = 8'b01000000,
    ST_SHOW  = 8'b10000000
  } state_e;

  typedef struct packed {
    logic        start;
    logic        by_ten;
    logic [31:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [5:0]  rem;
  } div_rsp_t;

  function automatic logic [7:0] seg_pattern(input logic [4:0] code);
    logic [7:0] pat;
    unique case (code)
      5'd0:    pat = 8'hBB;
      5'd1:    pat = 8'h28;
      5'd2:    pat = 8'h73;
      5'd3:    pat = 8'h79;
      5'd4:    pat = 8'hE8;
      5'd5:    pat = 8'hD9;
      5'd6:    pat = 8'hDB;
      5'd7:    pat = 8'h38;
      5'd8:    pat = 8'hFB;
      5'd9:    pat = 8'hF9;
      5'd10:   pat = 8'hFA;
      5'd11:   pat = 8'hCB;
      5'd12:   pat = 8'h43;
      5'd13:   pat = 8'h6B;
      5'd14:   pat = 8'hD3;
      5'd15:   pat = 8'hD2;
      5'd16:   pat = 8'h40;
      5'd17:   pat = 8'h93;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

/* hdl/ecss_div.sv */
// Shared divider by 60 or by 10: one reciprocal multiplier, with operand, product and result registers in turn.
// Depends on ecss_pkg for the request and response structs and the reciprocals.
module ecss_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ecss_pkg::div_req_t req_i,
  output ecss_pkg::div_rsp_t rsp_o
);

  logic        load_q, load_d;
  logic        mul_q, mul_d;
  logic        done_q, done_d;
  logic        ten_q, ten_d;
  logic [31:0] opd_q, opd_d;
  logic [63:0] prod_q, prod_d;
  logic [31:0] quo_q, quo_d;
  logic [5:0]  rem_q, rem_d;
  logic [31:0] recip;
  logic [31:0] quot;
  logic [5:0]  back;

  assign load_d = req_i.start;
  assign mul_d  = load_q;
  assign done_d = mul_q;

  assign recip = ten_q ? ecss_pkg::RECIP_DECIMAL : ecss_pkg::RECIP_MINUTE;
  assign quot  = ten_q ? prod_q[ecss_pkg::SHIFT_DECIMAL +: 32]
                       : 32'(prod_q[63:ecss_pkg::SHIFT_MINUTE]);
  // low six bits of quot * divisor; the remainder fits in six bits
  assign back  = ten_q ? ({quot[2:0], 3'b000} + {quot[4:0], 1'b0})
                       : (6'd0 - {quot[3:0], 2'b00});

  always_comb begin
    ten_d  = ten_q;
    opd_d  = opd_q;
    prod_d = prod_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      ten_d = req_i.by_ten;
      opd_d = req_i.dividend;
    end
    if (load_q) begin
      prod_d = 64'(opd_q) * 64'(recip);
    end
    if (mul_q) begin
      quo_d = quot;
      rem_d = opd_q[5:0] - back;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= 1'b0;
      mul_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      load_q <= load_d;
      mul_q  <= mul_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ten_q  <= ten_d;
    opd_q  <= opd_d;
    prod_q <= prod_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

/* hdl/ecss_mem.sv */
// Schedule store: one write port, one read port with registered data.
// No package dependency; depth comes from the top level.
module ecss_mem #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/event_countdown_seven_segment.sv */
// Top level: sequencer that walks the schedule and formats the countdown display.
// Depends on ecss_pkg, ecss_mem (schedule store) and ecss_div (shared divider).
//
//  channel | handshake               | beat fields
//  --------+-------------------------+-----------------------------------------------
//  in      | start / busy            | cmd_i entry_index_i entry_time_i now_i
//  out     | result_strobe_o (1 cyc) | result_kind_o left/middle/right_pattern_o
//          |                         | entry_position_o schedule_done_o
//          |                         | digit_enable_o scan_segments_o
//
// Write beats complete in the idle state without raising busy; a scan beat gives its result on the next cycle.
// A time beat holds busy while it walks past entries that are already due, then for up to three
// divides (by 60, then by 10 once or twice) on the shared divider; the result is strobed in the
// cycle in which busy drops.
// After reset a clearing pass writes zero to every entry of the store; busy is high.
// Results are strobed for one cycle and are not held off by the receiver.
module event_countdown_seven_segment #(
  parameter int unsigned SCHEDULE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [5:0]  entry_index_i,
  input  logic [31:0] entry_time_i,
  input  logic [31:0] now_i,
  output logic        result_strobe_o,
  output logic        result_kind_o,
  output logic [7:0]  left_pattern_o,
  output logic [7:0]  middle_pattern_o,
  output logic [7:0]  right_pattern_o,
  output logic [6:0]  entry_position_o,
  output logic        schedule_done_o,
  output logic [2:0]  digit_enable_o,
  output logic [7:0]  scan_segments_o
);

  localparam int unsigned AW = $clog2(SCHEDULE_DEPTH);
  localparam int unsigned PW = $clog2(SCHEDULE_DEPTH + 1);

  ecss_pkg::state_e state_q, state_d;

  logic [PW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [31:0]   now_q, now_d;
  logic          flag_q, flag_d;
  logic [3:0]    low_q, low_d;
  logic [1:0]    scan_q, scan_d;
  logic [7:0]    shown_q [3];
  logic [7:0]    shown_d [3];

  logic       strobe_q, strobe_d;
  logic       kind_q, kind_d;
  logic [7:0] left_q, left_d;
  logic [7:0] mid_q, mid_d;
  logic [7:0] right_q, right_d;
  logic [6:0] pos_q, pos_d;
  logic       sdone_q, sdone_d;
  logic [2:0] den_q, den_d;
  logic [7:0] sseg_q, sseg_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          mem_re;
  logic [31:0]   mem_rdata;

  ecss_pkg::div_req_t div_req;
  ecss_pkg::div_rsp_t div_rsp;

  logic [31:0] idx_ext;
  logic [31:0] ptr_ext;
  logic [1:0]  scan_pos;
  logic        ptr_at_end;
  logic        over_limit;

  assign idx_ext    = 32'(entry_index_i);
  assign ptr_ext    = 32'(ptr_q);
  assign scan_pos   = (scan_q == 2'd3) ? 2'd0 : scan_q;
  assign ptr_at_end = ptr_q == PW'(SCHEDULE_DEPTH);
  assign over_limit = ptr_q[0] ? (div_rsp.quot > ecss_pkg::MAX_END_MIN)
                               : (div_rsp.quot > ecss_pkg::MAX_START_MIN);

  ecss_mem #(
    .DEPTH (SCHEDULE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  ecss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    clr_d     = clr_q;
    now_d     = now_q;
    flag_d    = flag_q;
    low_d     = low_q;
    scan_d    = scan_q;
    shown_d   = shown_q;
    strobe_d  = 1'b0;
    kind_d    = kind_q;
    left_d    = left_q;
    mid_d     = mid_q;
    right_d   = right_q;
    pos_d     = pos_q;
    sdone_d   = sdone_q;
    den_d     = den_q;
    sseg_d    = sseg_q;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    div_req   = '0;

    unique case (state_q)
      ecss_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(SCHEDULE_DEPTH - 1)) begin
          state_d = ecss_pkg::ST_IDLE;
        end
      end
      ecss_pkg::ST_IDLE: begin
        if (start) begin
          unique case (cmd_i)
            ecss_pkg::CMD_WRITE: begin
              if (idx_ext < 32'(SCHEDULE_DEPTH)) begin
                mem_we    = 1'b1;
                mem_waddr = idx_ext[AW-1:0];
                mem_wdata = entry_time_i;
              end
            end
            ecss_pkg::CMD_TIME: begin
              now_d   = now_i;
              state_d = ecss_pkg::ST_WALK;
            end
            ecss_pkg::CMD_SCAN: begin
              strobe_d = 1'b1;
              kind_d   = ecss_pkg::KIND_SCAN;
              left_d   = '0;
              mid_d    = '0;
              right_d  = '0;
              pos_d    = '0;
              sdone_d  = 1'b0;
              sseg_d   = shown_q[scan_pos];
              unique case (scan_pos)
                2'd1:    den_d = 3'b010;
                2'd2:    den_d = 3'b100;
                default: den_d = 3'b001;
              endcase
              scan_d = (scan_pos == 2'd2) ? 2'd0 : scan_pos + 2'd1;
            end
            default: ;
          endcase
        end
      end
      ecss_pkg::ST_WALK: begin
        if (ptr_at_end) begin
          flag_d  = 1'b1;
          shown_d = '{ecss_pkg::PAT_E, ecss_pkg::PAT_ZERO, ecss_pkg::PAT_C};
          state_d = ecss_pkg::ST_SHOW;
        end else begin
          mem_re  = 1'b1;
          state_d = ecss_pkg::ST_CMP;
        end
      end
      ecss_pkg::ST_CMP: begin
        if (mem_rdata == '0) begin
          flag_d  = 1'b1;
          shown_d = '{ecss_pkg::PAT_E, ecss_pkg::PAT_ZERO, ecss_pkg::PAT_C};
          state_d = ecss_pkg::ST_SHOW;
        end else if (mem_rdata < now_q) begin
          ptr_d   = ptr_q + PW'(1);
          state_d = ecss_pkg::ST_WALK;
        end else begin
          flag_d           = 1'b0;
          div_req.start    = 1'b1;
          div_req.dividend = mem_rdata - now_q;
          state_d          = ecss_pkg::ST_DIV60;
        end
      end
      ecss_pkg::ST_DIV60: begin
        if (div_rsp.done) begin
          if (over_limit) begin
            shown_d = '{ecss_pkg::PAT_MINUS, ecss_pkg::PAT_MINUS, ecss_pkg::PAT_DOT};
            state_d = ecss_pkg::ST_SHOW;
          end else begin
            div_req.start    = 1'b1;
            div_req.by_ten   = 1'b1;
            div_req.dividend = div_rsp.quot;
            state_d          = ecss_pkg::ST_DIGA;
          end
        end
      end
      ecss_pkg::ST_DIGA: begin
        if (div_rsp.done) begin
          if (!ptr_q[0]) begin
            shown_d = '{ecss_pkg::seg_pattern(ecss_pkg::SEG_MINUS),
                        ecss_pkg::seg_pattern({1'b0, div_rsp.quot[3:0]}),
                        ecss_pkg::seg_pattern({1'b0, div_rsp.rem[3:0]})};
            state_d = ecss_pkg::ST_SHOW;
          end else begin
            low_d            = div_rsp.rem[3:0];
            div_req.start    = 1'b1;
            div_req.by_ten   = 1'b1;
            div_req.dividend = div_rsp.quot;
            state_d          = ecss_pkg::ST_DIGB;
          end
        end
      end
      ecss_pkg::ST_DIGB: begin
        if (div_rsp.done) begin
          shown_d = '{ecss_pkg::seg_pattern({1'b0, div_rsp.quot[3:0]}),
                      ecss_pkg::seg_pattern({1'b0, div_rsp.rem[3:0]}),
                      ecss_pkg::seg_pattern({1'b0, low_q})};
          state_d = ecss_pkg::ST_SHOW;
        end
      end
      ecss_pkg::ST_SHOW: begin
        strobe_d = 1'b1;
        kind_d   = ecss_pkg::KIND_TIME;
        left_d   = shown_q[0];
        mid_d    = shown_q[1];
        right_d  = shown_q[2];
        pos_d    = ptr_ext[6:0];
        sdone_d  = flag_q;
        den_d    = '0;
        sseg_d   = '0;
        state_d  = ecss_pkg::ST_IDLE;
      end
      default: state_d = ecss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ecss_pkg::ST_CLEAR;
      ptr_q    <= '0;
      clr_q    <= '0;
      scan_q   <= '0;
      shown_q  <= '{default: 8'h00};
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      clr_q    <= clr_d;
      scan_q   <= scan_d;
      shown_q  <= shown_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    flag_q  <= flag_d;
    low_q   <= low_d;
    kind_q  <= kind_d;
    left_q  <= left_d;
    mid_q   <= mid_d;
    right_q <= right_d;
    pos_q   <= pos_d;
    sdone_q <= sdone_d;
    den_q   <= den_d;
    sseg_q  <= sseg_d;
  end

  assign busy             = state_q != ecss_pkg::ST_IDLE;
  assign result_strobe_o  = strobe_q;
  assign result_kind_o    = kind_q;
  assign left_pattern_o   = left_q;
  assign middle_pattern_o = mid_q;
  assign right_pattern_o  = right_q;
  assign entry_position_o = pos_q;
  assign schedule_done_o  = sdone_q;
  assign digit_enable_o   = den_q;
  assign scan_segments_o  = sseg_q;

endmodule

/* hdl/ecss_chk.sv */
// Port-level checker for the event countdown display, bound to the top level.
// Depends on ecss_pkg for command codes and display patterns.
module ecss_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  cmd_i,
  input logic        result_strobe_o,
  input logic        result_kind_o,
  input logic [7:0]  left_pattern_o,
  input logic [7:0]  middle_pattern_o,
  input logic [7:0]  right_pattern_o,
  input logic        schedule_done_o,
  input logic [2:0]  digit_enable_o,
  input logic [7:0]  scan_segments_o
);

  a_scan_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && result_kind_o |->
      $onehot(digit_enable_o) && left_pattern_o == '0 &&
      middle_pattern_o == '0 && right_pattern_o == '0)
    else $error("scan beat with bad digit select or display fields");

  a_time_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !result_kind_o |->
      digit_enable_o == '0 && scan_segments_o == '0 && $past(busy))
    else $error("time beat with scan fields set or without a busy phase");

  a_end_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !result_kind_o && schedule_done_o |->
      left_pattern_o == ecss_pkg::PAT_E && middle_pattern_o == ecss_pkg::PAT_ZERO &&
      right_pattern_o == ecss_pkg::PAT_C)
    else $error("end of schedule not shown as E0C");

  a_time_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i == ecss_pkg::CMD_TIME |=> busy && !result_strobe_o)
    else $error("time beat taken without going busy");

endmodule

bind event_countdown_seven_segment ecss_chk u_ecss_chk (.*);
